// ===== rtl/motion_command_table_top_macros.svh =====
// Assertion macros for the motion command table checker.
// Used by mct_checker.sv; no other dependencies.
`ifndef MOTION_COMMAND_TABLE_TOP_MACROS_SVH
`define MOTION_COMMAND_TABLE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define MCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("motion command table check failed");

// next-cycle implication, held off during reset
`define MCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("motion command table check failed");

`endif

// ===== rtl/mct_pkg.sv =====
// Shared types and codes for the motion command table.
// No dependencies; used by every module of the block but mct_ram.
`default_nettype none

package mct_pkg;

	localparam logic [7:0] ID_IMMEDIATE = 8'hfe;
	localparam logic [7:0] ID_GENERAL   = 8'hff;
	localparam logic [7:0] ID_NO_TASK   = 8'hff;

	localparam logic [2:0] ACT_INSERT     = 3'd0;
	localparam logic [2:0] ACT_DELETE     = 3'd1;
	localparam logic [2:0] ACT_UPDATE     = 3'd2;
	localparam logic [2:0] ACT_DELETE_ALL = 3'd3;

	localparam logic [2:0] ST_ACK       = 3'd0;
	localparam logic [2:0] ST_PROTOCOL  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_COMPLETE  = 3'd4;
	localparam logic [2:0] ST_NO_TASK   = 3'd5;

	localparam logic [2:0] DIR_FORWARD  = 3'd0;
	localparam logic [2:0] DIR_BACKWARD = 3'd1;
	localparam logic [2:0] DIR_CW       = 3'd2;
	localparam logic [2:0] DIR_ACW      = 3'd3;

	typedef struct packed {
		logic [7:0]  id;
		logic [2:0]  dir;
		logic [7:0]  duty_l;
		logic [7:0]  duty_r;
		logic [15:0] dur;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        func;
		logic [2:0]  action;
		logic [7:0]  cmd_id;
		logic [2:0]  direction;
		logic [7:0]  duty_left;
		logic [7:0]  duty_right;
		logic [15:0] duration;
	} item_t;

	typedef struct packed {
		logic [7:0]  result_id;
		logic [2:0]  status;
		logic [15:0] run_time;
		logic        drive_valid;
		logic        left_forward;
		logic        right_forward;
		logic [7:0]  left_duty;
		logic [7:0]  right_duty;
		logic [7:0]  exec_position;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_SRCH,
		S_SHIFT,
		S_DONE
	} seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/mct_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mct_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 252
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mct_seq.sv =====
// Sequencer for the motion command table: decode, search, shift and execute
// over the entry RAM. Depends on mct_pkg and mct_ram.
`default_nettype none

module mct_seq #(
	parameter int DEPTH = 252
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire mct_pkg::item_t   item,
	output logic                  item_stall,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output mct_pkg::result_t      res
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	mct_pkg::seq_state_t state_q, state_d;
	mct_pkg::item_t      item_q;
	mct_pkg::result_t    res_q, res_d;

	logic [AW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] hit_q, hit_d;
	logic [AW-1:0] ridx_s1, ridx_d;
	logic          rv_s1, rv_d;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	mct_pkg::entry_t      ram_wdata, rd_entry;
	logic [mct_pkg::ENTRY_W-1:0] ram_rdata;

	logic match;
	logic accept;

	mct_ram #(
		.WIDTH(mct_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = mct_pkg::entry_t'(ram_rdata);
	assign match    = rv_s1 && (rd_entry.id == item_q.cmd_id);
	assign accept   = item_valid && !item_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mct_pkg::S_IDLE: begin
				if (item_valid) state_d = mct_pkg::S_DECODE;
			end
			mct_pkg::S_DECODE: begin
				if (item_q.func) begin
					state_d = (ptr_q < count_q) ? mct_pkg::S_EXEC : mct_pkg::S_DONE;
				end else if (item_q.cmd_id == mct_pkg::ID_IMMEDIATE ||
						item_q.cmd_id == mct_pkg::ID_GENERAL) begin
					state_d = mct_pkg::S_DONE;
				end else if ((item_q.action == mct_pkg::ACT_DELETE ||
						item_q.action == mct_pkg::ACT_UPDATE) && count_q != '0) begin
					state_d = mct_pkg::S_SRCH;
				end else begin
					state_d = mct_pkg::S_DONE;
				end
			end
			mct_pkg::S_EXEC: state_d = mct_pkg::S_DONE;
			mct_pkg::S_SRCH: begin
				if (match) begin
					state_d = (item_q.action == mct_pkg::ACT_UPDATE) ?
						mct_pkg::S_DONE : mct_pkg::S_SHIFT;
				end else if (idx_q >= count_q && !rv_s1) begin
					state_d = mct_pkg::S_DONE;
				end
			end
			mct_pkg::S_SHIFT: begin
				if (!rv_s1 && idx_q >= count_q) state_d = mct_pkg::S_DONE;
			end
			mct_pkg::S_DONE: begin
				if (res_ready) state_d = mct_pkg::S_IDLE;
			end
			default: state_d = mct_pkg::S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		item_stall = (state_q != mct_pkg::S_IDLE);
		res_valid  = (state_q == mct_pkg::S_DONE);
		res        = res_q;
		res.exec_position = 8'(ptr_q);
	end

	// datapath and RAM control
	always_comb begin
		count_d   = count_q;
		ptr_d     = ptr_q;
		idx_d     = idx_q;
		hit_d     = hit_q;
		ridx_d    = ridx_s1;
		rv_d      = 1'b0;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rd_entry;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			mct_pkg::S_DECODE: begin
				res_d = '0;
				res_d.result_id = item_q.cmd_id;
				res_d.status    = mct_pkg::ST_PROTOCOL;
				if (item_q.func) begin
					if (ptr_q < count_q) begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q;
					end else begin
						res_d.result_id = mct_pkg::ID_NO_TASK;
						res_d.status    = mct_pkg::ST_NO_TASK;
					end
				end else if (item_q.cmd_id == mct_pkg::ID_IMMEDIATE) begin
					if (item_q.action == mct_pkg::ACT_DELETE_ALL) begin
						count_d      = '0;
						ptr_d        = '0;
						res_d.status = mct_pkg::ST_ACK;
					end
				end else if (item_q.cmd_id == mct_pkg::ID_GENERAL) begin
					if (item_q.action == mct_pkg::ACT_INSERT) begin
						ram_we    = 1'b1;
						ram_waddr = count_q;
						ram_wdata = '{id: 8'(count_q), dir: item_q.direction,
							duty_l: item_q.duty_left, duty_r: item_q.duty_right,
							dur: item_q.duration};
						if (count_q != LAST_SLOT) begin
							count_d         = count_q + AW'(1);
							res_d.result_id = 8'(count_q);
							res_d.status    = mct_pkg::ST_ACK;
						end else begin
							count_d         = '0;
							res_d.result_id = 8'd0;
							res_d.status    = mct_pkg::ST_OVERFLOW;
						end
					end
				end else if (item_q.action == mct_pkg::ACT_DELETE ||
						item_q.action == mct_pkg::ACT_UPDATE) begin
					res_d.status = mct_pkg::ST_NOT_FOUND;
					idx_d        = '0;
				end
			end
			mct_pkg::S_EXEC: begin
				res_d.result_id = rd_entry.id;
				if (rd_entry.dir <= mct_pkg::DIR_ACW) begin
					res_d.status        = mct_pkg::ST_COMPLETE;
					res_d.run_time      = rd_entry.dur;
					res_d.drive_valid   = 1'b1;
					res_d.left_forward  = (rd_entry.dir == mct_pkg::DIR_FORWARD ||
						rd_entry.dir == mct_pkg::DIR_CW);
					res_d.right_forward = (rd_entry.dir == mct_pkg::DIR_FORWARD ||
						rd_entry.dir == mct_pkg::DIR_ACW);
					res_d.left_duty     = rd_entry.duty_l;
					res_d.right_duty    = rd_entry.duty_r;
					ptr_d               = ptr_q + AW'(1);
				end
			end
			mct_pkg::S_SRCH: begin
				// one read per cycle until a match; the compare uses registered data
				if (match) begin
					hit_d = ridx_s1;
					if (item_q.action == mct_pkg::ACT_UPDATE) begin
						ram_we    = 1'b1;
						ram_waddr = ridx_s1;
						ram_wdata = '{id: item_q.cmd_id, dir: item_q.direction,
							duty_l: item_q.duty_left, duty_r: item_q.duty_right,
							dur: item_q.duration};
						res_d.status = mct_pkg::ST_ACK;
					end else begin
						idx_d = ridx_s1 + AW'(1);
					end
				end else if (idx_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_q;
					ridx_d    = idx_q;
					rv_d      = 1'b1;
					idx_d     = idx_q + AW'(1);
				end
			end
			mct_pkg::S_SHIFT: begin
				// read entry i+1 while writing entry i, already read, back to slot i-1
				if (rv_s1) begin
					ram_we    = 1'b1;
					ram_waddr = ridx_s1 - AW'(1);
					ram_wdata = rd_entry;
				end
				if (idx_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_q;
					ridx_d    = idx_q;
					rv_d      = 1'b1;
					idx_d     = idx_q + AW'(1);
				end else if (!rv_s1) begin
					count_d      = count_q - AW'(1);
					if (ptr_q > hit_q) ptr_d = ptr_q - AW'(1);
					res_d.status = mct_pkg::ST_ACK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mct_pkg::S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			rv_s1   <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		res_q   <= res_d;
		idx_q   <= idx_d;
		hit_q   <= hit_d;
		ridx_s1 <= ridx_d;
	end

endmodule

`default_nettype wire

// ===== rtl/mct_out.sv =====
// Output register for the motion command table result channel.
// Depends on mct_pkg.
`default_nettype none

module mct_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire mct_pkg::result_t res,
	output logic                  res_ready,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output mct_pkg::result_t      out_res
);

	logic             valid_q;
	mct_pkg::result_t data_q;

	// free when empty or when the held result is transferred this cycle
	assign res_ready = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/motion_command_table_top.sv =====
// Motion command table: one result per item, one item at a time.
// Clear, insert and no-task go from decode to done; execute reads the entry in
// decode and builds the result in EXEC; delete/update scan, and a delete shifts.
// The next item is taken in idle, after the result enters the output register;
// the scan and shift over the entry RAM's single read port set the worst case.
// Reset clears count, pointer and handshake state; RAM contents are not cleared.
`default_nettype none

module motion_command_table_top #(
	parameter int TABLE_DEPTH = 252
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  cmd_id,
	input  wire logic [2:0]  direction,
	input  wire logic [7:0]  duty_left,
	input  wire logic [7:0]  duty_right,
	input  wire logic [15:0] duration,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       result_id,
	output logic [2:0]       status,
	output logic [15:0]      run_time,
	output logic             drive_valid,
	output logic             left_forward,
	output logic             right_forward,
	output logic [7:0]       left_duty,
	output logic [7:0]       right_duty,
	output logic [7:0]       exec_position
);

	mct_pkg::item_t   item;
	mct_pkg::result_t res, out_res;
	logic             res_valid, res_ready;

	assign item = '{func: func, action: action, cmd_id: cmd_id, direction: direction,
		duty_left: duty_left, duty_right: duty_right, duration: duration};

	mct_seq #(
		.DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid),
		.item       (item),
		.item_stall (in_stall),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	mct_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign result_id     = out_res.result_id;
	assign status        = out_res.status;
	assign run_time      = out_res.run_time;
	assign drive_valid   = out_res.drive_valid;
	assign left_forward  = out_res.left_forward;
	assign right_forward = out_res.right_forward;
	assign left_duty     = out_res.left_duty;
	assign right_duty    = out_res.right_duty;
	assign exec_position = out_res.exec_position;

endmodule

`default_nettype wire

// ===== rtl/mct_checker.sv =====
// Port-level checks for motion_command_table_top, attached by bind.
// Depends on mct_pkg and motion_command_table_top_macros.svh.
`default_nettype none

`include "motion_command_table_top_macros.svh"

module mct_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  result_id,
	input wire logic [2:0]  status,
	input wire logic [15:0] run_time,
	input wire logic        drive_valid,
	input wire logic        left_forward,
	input wire logic        right_forward,
	input wire logic [7:0]  left_duty,
	input wire logic [7:0]  right_duty
);

	// a stalled result holds until transferred
	`MCT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_id) && $stable(status) && $stable(run_time))

	// drive fields are zero unless drive_valid marks a completed execution
	`MCT_ASSERT_IMP(a_drive_zero, clk, arst_n, out_valid && !drive_valid, !left_forward && !right_forward && left_duty == 8'd0 && right_duty == 8'd0)

	// run time only on a completed execution
	`MCT_ASSERT_IMP(a_run_time, clk, arst_n, out_valid && status != mct_pkg::ST_COMPLETE, run_time == 16'd0 && !drive_valid)

	// nothing to execute reports the reserved id
	`MCT_ASSERT_IMP(a_no_task_id, clk, arst_n, out_valid && status == mct_pkg::ST_NO_TASK, result_id == mct_pkg::ID_NO_TASK)

endmodule

bind motion_command_table_top mct_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.result_id     (result_id),
	.status        (status),
	.run_time      (run_time),
	.drive_valid   (drive_valid),
	.left_forward  (left_forward),
	.right_forward (right_forward),
	.left_duty     (left_duty),
	.right_duty    (right_duty)
);

`default_nettype wire

// ===== sim/motion_command_table_top_tb.sv =====
// Self-checking testbench for motion_command_table_top: random and directed table
// commands and executes, with a predictor of the table in a small scoreboard class.
// Depends on mct_pkg and the motion_command_table_top RTL only.

module motion_command_table_top_tb;

	localparam int TABLE_DEPTH = 252;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEMS_PER_PHASE = 250;

	class command_table_tracker;
		mct_pkg::entry_t  slots[TABLE_DEPTH];
		int unsigned      count;
		int unsigned      ptr;
		int unsigned      errors;
		mct_pkg::result_t expected_replies[$];

		function mct_pkg::result_t predict_reply(mct_pkg::item_t it);
			mct_pkg::result_t r;
			mct_pkg::entry_t  e;
			int unsigned      slot;
			int unsigned      k;
			bit               hit;
			r = '0;
			r.result_id = it.cmd_id;
			r.status = mct_pkg::ST_PROTOCOL;
			hit = 1'b0;
			k = 0;
			if (it.func) begin
				if (ptr < count) begin
					e = slots[ptr];
					r.result_id = e.id;
					// a bad stored direction leaves the pointer where it is
					if (e.dir <= mct_pkg::DIR_ACW) begin
						r.status = mct_pkg::ST_COMPLETE;
						r.run_time = e.dur;
						r.drive_valid = 1'b1;
						r.left_forward = (e.dir == mct_pkg::DIR_FORWARD ||
							e.dir == mct_pkg::DIR_CW);
						r.right_forward = (e.dir == mct_pkg::DIR_FORWARD ||
							e.dir == mct_pkg::DIR_ACW);
						r.left_duty = e.duty_l;
						r.right_duty = e.duty_r;
						ptr++;
					end
				end else begin
					r.result_id = mct_pkg::ID_NO_TASK;
					r.status = mct_pkg::ST_NO_TASK;
				end
			end else if (it.cmd_id == mct_pkg::ID_IMMEDIATE) begin
				if (it.action == mct_pkg::ACT_DELETE_ALL) begin
					count = 0;
					ptr = 0;
					r.status = mct_pkg::ST_ACK;
				end
			end else if (it.cmd_id == mct_pkg::ID_GENERAL) begin
				if (it.action == mct_pkg::ACT_INSERT) begin
					slot = count % TABLE_DEPTH;
					slots[slot] = {8'(slot), it.direction, it.duty_left, it.duty_right,
						it.duration};
					if (slot <= TABLE_DEPTH - 2) begin
						count = slot + 1;
						r.result_id = 8'(slot);
						r.status = mct_pkg::ST_ACK;
					end else begin
						count = 0;
						r.result_id = '0;
						r.status = mct_pkg::ST_OVERFLOW;
					end
				end
			end else if (it.action == mct_pkg::ACT_DELETE ||
					it.action == mct_pkg::ACT_UPDATE) begin
				for (int i = 0; i < count; i++)
					if (!hit && slots[i].id == it.cmd_id) begin
						hit = 1'b1;
						k = i;
					end
				if (!hit) begin
					r.status = mct_pkg::ST_NOT_FOUND;
				end else if (it.action == mct_pkg::ACT_UPDATE) begin
					slots[k] = {it.cmd_id, it.direction, it.duty_left, it.duty_right,
						it.duration};
					r.status = mct_pkg::ST_ACK;
				end else begin
					for (int i = k; i + 1 < count; i++)
						slots[i] = slots[i + 1];
					count--;
					if (ptr > k)
						ptr--;
					r.status = mct_pkg::ST_ACK;
				end
			end
			r.exec_position = 8'(ptr);
			return r;
		endfunction

		function void note_command(mct_pkg::item_t it);
			expected_replies.push_back(predict_reply(it));
		endfunction

		function int unsigned pending();
			return expected_replies.size();
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want)
				report($sformatf("%s expected %0d got %0d", name, want, got));
		endtask

		task check_reply(mct_pkg::result_t got);
			mct_pkg::result_t want;
			if (expected_replies.size() == 0) begin
				report($sformatf("reply with nothing outstanding (id %0d status %0d)",
					got.result_id, got.status));
				return;
			end
			want = expected_replies.pop_front();
			compare("result_id", want.result_id, got.result_id);
			compare("status", want.status, got.status);
			compare("run_time", want.run_time, got.run_time);
			compare("drive_valid", want.drive_valid, got.drive_valid);
			compare("left_forward", want.left_forward, got.left_forward);
			compare("right_forward", want.right_forward, got.right_forward);
			compare("left_duty", want.left_duty, got.left_duty);
			compare("right_duty", want.right_duty, got.right_duty);
			compare("exec_position", want.exec_position, got.exec_position);
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [2:0]  action = '0;
	logic [7:0]  cmd_id = '0;
	logic [2:0]  direction = '0;
	logic [7:0]  duty_left = '0;
	logic [7:0]  duty_right = '0;
	logic [15:0] duration = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  result_id;
	logic [2:0]  status;
	logic [15:0] run_time;
	logic        drive_valid;
	logic        left_forward;
	logic        right_forward;
	logic [7:0]  left_duty;
	logic [7:0]  right_duty;
	logic [7:0]  exec_position;

	int unsigned tx_idle_pct = 31;
	int unsigned rx_idle_pct = 66;

	command_table_tracker tracker = new;

	motion_command_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.action(action),
		.cmd_id(cmd_id),
		.direction(direction),
		.duty_left(duty_left),
		.duty_right(duty_right),
		.duration(duration),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_id(result_id),
		.status(status),
		.run_time(run_time),
		.drive_valid(drive_valid),
		.left_forward(left_forward),
		.right_forward(right_forward),
		.left_duty(left_duty),
		.right_duty(right_duty),
		.exec_position(exec_position)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// outputs sampled at the edge, before the block's registers move
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_reply({result_id, status, run_time, drive_valid, left_forward,
				right_forward, left_duty, right_duty, exec_position});
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("motion_command_table_top regression: fail");
		$finish;
	end

	function mct_pkg::item_t cmd(logic f, logic [2:0] act, logic [7:0] id,
			logic [2:0] dir, logic [7:0] dl, logic [7:0] dr, logic [15:0] dur);
		return {f, act, id, dir, dl, dr, dur};
	endfunction

	function logic [2:0] pick_direction();
		if ($urandom_range(99) < 85)
			return 3'($urandom_range(3));
		return 3'($urandom_range(7, 4));
	endfunction

	function mct_pkg::item_t insert_cmd(logic [2:0] dir, logic [7:0] dl, logic [7:0] dr,
			logic [15:0] dur);
		return cmd(1'b0, mct_pkg::ACT_INSERT, mct_pkg::ID_GENERAL, dir, dl, dr, dur);
	endfunction

	function mct_pkg::item_t random_insert();
		return insert_cmd(pick_direction(), 8'($urandom), 8'($urandom), 16'($urandom));
	endfunction

	// execute ignores the rest of the payload, so fill it with noise
	function mct_pkg::item_t run_next();
		return cmd(1'b1, 3'($urandom), 8'($urandom), 3'($urandom), 8'($urandom),
			8'($urandom), 16'($urandom));
	endfunction

	function logic [7:0] pick_target();
		if (tracker.count != 0 && $urandom_range(4) != 0)
			return tracker.slots[$urandom_range(tracker.count - 1)].id;
		return 8'($urandom_range(253));
	endfunction

	function mct_pkg::item_t random_command();
		mct_pkg::item_t it;
		int unsigned    r;
		it = cmd(1'b0, 3'($urandom), 8'($urandom), pick_direction(), 8'($urandom),
			8'($urandom), 16'($urandom));
		r = $urandom_range(99);
		if (r < 30) begin
			it.action = mct_pkg::ACT_INSERT;
			it.cmd_id = mct_pkg::ID_GENERAL;
		end else if (r < 55) begin
			it.func = 1'b1;
		end else if (r < 79) begin
			it.action = (r < 67) ? mct_pkg::ACT_DELETE : mct_pkg::ACT_UPDATE;
			it.cmd_id = pick_target();
		end else if (r < 83) begin
			it.action = mct_pkg::ACT_DELETE_ALL;
			it.cmd_id = mct_pkg::ID_IMMEDIATE;
		end else if (r < 88) begin
			it.cmd_id = mct_pkg::ID_IMMEDIATE;
		end else if (r < 93) begin
			it.cmd_id = mct_pkg::ID_GENERAL;
		end else begin
			it.func = 1'($urandom);
		end
		return it;
	endfunction

	task send_command(mct_pkg::item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		func <= it.func;
		action <= it.action;
		cmd_id <= it.cmd_id;
		direction <= it.direction;
		duty_left <= it.duty_left;
		duty_right <= it.duty_right;
		duration <= it.duration;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		tracker.note_command(it);
	endtask

	task hold_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	// fill every slot, then wrap the count so the pointer is left above it
	task fill_to_overflow();
		for (int s = 0; s < TABLE_DEPTH - 1; s++)
			send_command(random_insert());
		repeat (3) send_command(run_next());
		send_command(cmd(1'b0, mct_pkg::ACT_UPDATE, 8'(TABLE_DEPTH - 2), pick_direction(),
			8'($urandom), 8'($urandom), 16'($urandom)));
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, 8'd0, 3'd0, 8'd0, 8'd0, 16'd0));
		repeat (2) send_command(random_insert());
		send_command(run_next());
		repeat (2) send_command(random_insert());
		send_command(run_next());
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE_ALL, mct_pkg::ID_IMMEDIATE, 3'd0,
			8'd0, 8'd0, 16'd0));
	endtask

	task random_phase(int unsigned tx_pct, int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			send_command(random_command());
			if ($urandom_range(49) == 0)
				hold_until_drained();
		end
		hold_until_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, malformed commands
		send_command(run_next());
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, 8'd0, 3'd0, 8'd0, 8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_UPDATE, 8'd253, mct_pkg::DIR_CW, 8'd1, 8'd2,
			16'd3));
		send_command(cmd(1'b0, mct_pkg::ACT_INSERT, mct_pkg::ID_IMMEDIATE, 3'd0, 8'd0,
			8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, mct_pkg::ID_GENERAL, 3'd0, 8'd0,
			8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_INSERT, 8'd9, 3'd0, 8'd0, 8'd0, 16'd0));
		send_command(cmd(1'b0, 3'd7, 8'd9, 3'd7, 8'hff, 8'hff, 16'hffff));
		// one entry per direction plus one with a bad direction
		send_command(insert_cmd(mct_pkg::DIR_FORWARD, 8'h00, 8'h00, 16'h0000));
		send_command(insert_cmd(mct_pkg::DIR_BACKWARD, 8'hff, 8'hff, 16'hffff));
		send_command(insert_cmd(mct_pkg::DIR_CW, 8'h55, 8'haa, 16'h5a5a));
		send_command(insert_cmd(mct_pkg::DIR_ACW, 8'haa, 8'h55, 16'ha5a5));
		send_command(insert_cmd(3'd7, 8'h0f, 8'hf0, 16'h1234));
		repeat (5) send_command(run_next());
		send_command(cmd(1'b0, mct_pkg::ACT_UPDATE, 8'd4, mct_pkg::DIR_BACKWARD, 8'h80,
			8'h01, 16'h8001));
		repeat (2) send_command(run_next());
		// deletes below the pointer pull it back
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, 8'd0, 3'd0, 8'd0, 8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, 8'd3, 3'd0, 8'd0, 8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE, 8'd200, 3'd0, 8'd0, 8'd0, 16'd0));
		send_command(cmd(1'b0, mct_pkg::ACT_DELETE_ALL, mct_pkg::ID_IMMEDIATE, 3'd0,
			8'd0, 8'd0, 16'd0));
		send_command(run_next());
		hold_until_drained();

		fill_to_overflow();
		hold_until_drained();

		random_phase(31, 66);
		random_phase(66, 31);
		random_phase(0, 0);

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("motion_command_table_top regression: pass");
		else
			$display("motion_command_table_top regression: fail");
		$finish;
	end

endmodule
